// File: hdl/dda_pkg.sv
// Shared types and constants for the DDA line rasterizer.
// No dependencies; imported by every module of the block.
package dda_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 32;
  localparam int ADDR_W = 12;
  localparam int DEF_GRID_SIDE = 64;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DEF_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // One classified line, ready for stepping (slope travels beside it).
  typedef struct packed {
    logic               steep;
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] count;
    logic [COORD_W-1:0] minor_start;
    logic [COLOR_W-1:0] color;
  } dda_job_t;

endpackage

// File: hdl/dda_front.sv
// Front end: accepts line requests, clamps and orders the endpoints,
// and computes the fixed-point slope with a bit-serial divider. Uses dda_pkg.
module dda_front import dda_pkg::*; #(
  parameter int GRID_SIDE = DEF_GRID_SIDE,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [COORD_W-1:0]         x_start,
  input  logic [COORD_W-1:0]         y_start,
  input  logic [COORD_W-1:0]         x_end,
  input  logic [COORD_W-1:0]         y_end,
  input  logic [COLOR_W-1:0]         line_color,
  output logic                       push,
  input  logic                       full,
  output dda_job_t                   job,
  output logic [FRACTION_BITS+1:0]   slope
);

  localparam int DIV_STEPS = COORD_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int SLOPE_W = FRACTION_BITS + 2;
  localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_SIDE - 1);

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] c);
    clamp = (c > MAX_COORD) ? MAX_COORD : c;
  endfunction

  front_state_t state, state_next;

  logic [DIV_STEPS-1:0] num;
  logic [DIV_STEPS-1:0] quo;
  logic [COORD_W-1:0]   rem;
  logic [COORD_W-1:0]   den;
  logic                 neg;
  logic [CNT_W-1:0]     cnt;

  logic accept;
  logic div_run;

  // classification of the incoming request
  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COORD_W-1:0] px, py, qx, qy;
  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COORD_W:0]   dy_s, dx_s;
  logic [COORD_W-1:0] dx_u, ady, dys_u, adx_s;
  logic               shallow;
  dda_job_t           job_c;
  logic               neg_c;
  logic [COORD_W-1:0] mag_c, den_c;

  always_comb begin
    ax = clamp(x_start);
    ay = clamp(y_start);
    bx = clamp(x_end);
    by = clamp(y_end);
    if (ax > bx) begin
      px = bx; py = by; qx = ax; qy = ay;
    end else begin
      px = ax; py = ay; qx = bx; qy = by;
    end
    dx_u = qx - px;
    dy_s = {1'b0, qy} - {1'b0, py};
    ady = dy_s[COORD_W] ? COORD_W'(-dy_s) : dy_s[COORD_W-1:0];
    shallow = (dx_u != '0) && (ady <= dx_u);
    // steep lines run with y rising
    if (py > qy) begin
      sx = qx; sy = qy; ex = px; ey = py;
    end else begin
      sx = px; sy = py; ex = qx; ey = qy;
    end
    dys_u = ey - sy;
    dx_s = {1'b0, ex} - {1'b0, sx};
    adx_s = dx_s[COORD_W] ? COORD_W'(-dx_s) : dx_s[COORD_W-1:0];
    job_c.color = line_color;
    if (shallow) begin
      job_c.steep = 1'b0;
      job_c.major_start = px;
      job_c.count = dx_u;
      job_c.minor_start = py;
      neg_c = dy_s[COORD_W];
      mag_c = ady;
      den_c = dx_u;
    end else begin
      job_c.steep = 1'b1;
      job_c.major_start = sy;
      job_c.count = dys_u;
      job_c.minor_start = sx;
      neg_c = dx_s[COORD_W];
      mag_c = adx_s;
      den_c = dys_u;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (start) state_next = (den_c == '0) ? FR_PUSH : FR_DIV;
      FR_DIV:  if (cnt == CNT_W'(1)) state_next = FR_PUSH;
      FR_PUSH: if (!full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != FR_IDLE);
    accept = (state == FR_IDLE) && start;
    div_run = (state == FR_DIV);
    push = (state == FR_PUSH) && !full;
  end

  logic [COORD_W:0] trial;
  logic             fits;
  always_comb begin
    trial = {rem, num[DIV_STEPS-1]};
    fits = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_c;
      neg <= neg_c;
      den <= den_c;
      num <= {mag_c, {FRACTION_BITS{1'b0}}};
      rem <= '0;
      quo <= '0;
      cnt <= CNT_W'(DIV_STEPS);
    end else if (div_run) begin
      num <= num << 1;
      rem <= fits ? COORD_W'(trial - {1'b0, den}) : trial[COORD_W-1:0];
      quo <= {quo[DIV_STEPS-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  // quotient never exceeds 2^FRACTION_BITS, so SLOPE_W bits hold it signed
  assign slope = neg ? SLOPE_W'(-quo[SLOPE_W-1:0]) : quo[SLOPE_W-1:0];

endmodule

// File: hdl/dda_queue.sv
// Small FIFO between the front end and the stepping back end.
// Uses dda_pkg for the default depth.
module dda_queue import dda_pkg::*; #(
  parameter int DATA_W = 64,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/dda_back.sv
// Back end: takes classified lines from the queue and steps them,
// one pixel write per cycle within a line, through a fixed-point accumulator. Uses dda_pkg.
module dda_back import dda_pkg::*; #(
  parameter int GRID_SIDE = DEF_GRID_SIDE,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     empty,
  output logic                     pop,
  input  dda_job_t                 job,
  input  logic [FRACTION_BITS+1:0] slope,
  output logic                     pixel_valid,
  output logic [ADDR_W-1:0]        pixel_address,
  output logic [COLOR_W-1:0]       pixel_color,
  output logic                     last_pixel
);

  localparam int SLOPE_W = FRACTION_BITS + 2;
  localparam int ACC_W = COORD_W + FRACTION_BITS;

  back_state_t state, state_next;

  logic                 steep;
  logic [COORD_W-1:0]   major;
  logic [COORD_W-1:0]   remaining;
  logic [ACC_W-1:0]     acc;
  logic [SLOPE_W-1:0]   step;
  logic [COLOR_W-1:0]   color;

  logic                 emit;
  logic                 at_end;
  logic [COORD_W-1:0]   minor;
  logic [COORD_W-1:0]   px, py;
  logic [ADDR_W-1:0]    addr;

  always_comb begin
    at_end = (remaining == '0);
    minor = acc[ACC_W-1:FRACTION_BITS];
    px = steep ? minor : major;
    py = steep ? major : minor;
    addr = ADDR_W'({{(ADDR_W-COORD_W){1'b0}}, py} * ADDR_W'(GRID_SIDE))
         + {{(ADDR_W-COORD_W){1'b0}}, px};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!empty) state_next = BK_RUN;
      BK_RUN:  if (at_end) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == BK_IDLE) && !empty;
    emit = (state == BK_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      pixel_valid <= 1'b0;
    end else begin
      state <= state_next;
      pixel_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      steep <= job.steep;
      major <= job.major_start;
      remaining <= job.count;
      acc <= {job.minor_start, {FRACTION_BITS{1'b0}}};
      step <= slope;
      color <= job.color;
    end else if (emit) begin
      major <= major + COORD_W'(1);
      remaining <= remaining - COORD_W'(1);
      acc <= acc + {{(ACC_W-SLOPE_W){step[SLOPE_W-1]}}, step};
    end
    if (emit) begin
      pixel_address <= addr;
      pixel_color <= color;
      last_pixel <= at_end;
    end
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == BK_IDLE) && !empty)
    else $error("pop outside idle or from empty queue");
  a_end_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) && at_end |=> (state == BK_IDLE) && pixel_valid)
    else $error("line end did not return to idle");
  a_last_marks_valid: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && last_pixel |=> !pixel_valid)
    else $error("pixel emitted right after last pixel");
  a_minor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (minor <= COORD_W'(GRID_SIDE - 1)))
    else $error("minor coordinate left the grid");
`endif

endmodule

// File: hdl/dda_line_rasterizer.sv
// Front end divides over 6+FRACTION_BITS bits after acceptance, one divider
// step per cycle; single-point lines skip the divider. A line then passes
// through the queue and the back end's load state before its first pixel; the
// back end writes one pixel per cycle within a line, with an idle load state
// between lines. The front end can divide a new line while the back end steps.
// Synchronous active-high reset clears the control state; results cannot stall.
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int GRID_SIDE = DEF_GRID_SIDE,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] x_start,
  input  logic [COORD_W-1:0] y_start,
  input  logic [COORD_W-1:0] x_end,
  input  logic [COORD_W-1:0] y_end,
  input  logic [COLOR_W-1:0] line_color,
  output logic               pixel_valid,
  output logic [ADDR_W-1:0]  pixel_address,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               last_pixel
);

  localparam int SLOPE_W = FRACTION_BITS + 2;
  localparam int JOB_W = $bits(dda_job_t);
  localparam int Q_W = JOB_W + SLOPE_W;

  logic               push, full, pop, empty;
  dda_job_t           front_job, back_job;
  logic [SLOPE_W-1:0] front_slope, back_slope;
  logic [Q_W-1:0]     q_rd;

  dda_front #(
    .GRID_SIDE(GRID_SIDE),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .line_color(line_color),
    .push(push),
    .full(full),
    .job(front_job),
    .slope(front_slope)
  );

  dda_queue #(
    .DATA_W(Q_W),
    .DEPTH(DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_data({front_job, front_slope}),
    .full(full),
    .pop(pop),
    .rd_data(q_rd),
    .empty(empty)
  );

  assign back_job = dda_job_t'(q_rd[Q_W-1:SLOPE_W]);
  assign back_slope = q_rd[SLOPE_W-1:0];

  dda_back #(
    .GRID_SIDE(GRID_SIDE),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .pop(pop),
    .job(back_job),
    .slope(back_slope),
    .pixel_valid(pixel_valid),
    .pixel_address(pixel_address),
    .pixel_color(pixel_color),
    .last_pixel(last_pixel)
  );

endmodule

// File: sim/dda_line_rasterizer_tb.sv
// Self-checking testbench for dda_line_rasterizer: line requests go in through
// the start/busy command handshake and every pixel write is checked against an
// in-bench DDA predictor. Depends on dda_pkg and the rasterizer RTL.
`timescale 1ns / 100ps

module dda_line_rasterizer_tb;
  import dda_pkg::*;

  localparam int GRID_SIDE = DEF_GRID_SIDE;
  localparam int FRACTION_BITS = DEF_FRACTION_BITS;
  localparam int RANDOM_LINES = 400;

  typedef struct {
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COLOR_W-1:0] color;
  } line_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [COORD_W-1:0] x_start = '0;
  logic [COORD_W-1:0] y_start = '0;
  logic [COORD_W-1:0] x_end = '0;
  logic [COORD_W-1:0] y_end = '0;
  logic [COLOR_W-1:0] line_color = '0;
  logic               pixel_valid;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  line_req_t line_requests[$];
  pixel_t    expected_pixels[$];
  line_req_t next_req;
  pixel_t    got_pixel;
  int        lines_queued = 0;
  int        lines_issued = 0;
  int        lines_accepted = 0;
  int        error_count = 0;

  dda_line_rasterizer #(
    .GRID_SIDE(GRID_SIDE),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .line_color(line_color),
    .pixel_valid(pixel_valid),
    .pixel_address(pixel_address),
    .pixel_color(pixel_color),
    .last_pixel(last_pixel)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int saturate_coord(input logic [COORD_W-1:0] c);
    return (int'(c) > GRID_SIDE - 1) ? GRID_SIDE - 1 : int'(c);
  endfunction

  // Q.FRACTION_BITS ratio, truncated toward zero; den is always positive
  function automatic longint fixed_slope(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRACTION_BITS) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void push_pixel(input int x, input int y,
                                     input logic [COLOR_W-1:0] color, input logic last);
    pixel_t p;
    p.address = ADDR_W'(y * GRID_SIDE + x);
    p.color = color;
    p.last = last;
    expected_pixels.push_back(p);
  endfunction

  function automatic void predict_line_pixels(input line_req_t req);
    int     ax, ay, bx, by, t, dx, dy, ady, step;
    longint slope, acc;
    ax = saturate_coord(req.xs);
    ay = saturate_coord(req.ys);
    bx = saturate_coord(req.xe);
    by = saturate_coord(req.ye);
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = by - ay;
    ady = (dy < 0) ? -dy : dy;
    if (dx > 0 && ady <= dx) begin
      // shallow: step x, carry y
      slope = fixed_slope(dy, dx);
      acc = longint'(ay) <<< FRACTION_BITS;
      for (step = ax; step <= bx; step++) begin
        push_pixel(step, int'(acc >>> FRACTION_BITS), req.color, step == bx);
        acc += slope;
      end
    end else begin
      // steep or single point: order so y rises, step y, carry x
      if (ay > by) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      slope = (dy > 0) ? fixed_slope(dx, dy) : 0;
      acc = longint'(ax) <<< FRACTION_BITS;
      for (step = ay; step <= by; step++) begin
        push_pixel(int'(acc >>> FRACTION_BITS), step, req.color, step == by);
        acc += slope;
      end
    end
  endfunction

  function automatic logic [COORD_W-1:0] fit_coord(input int v);
    return COORD_W'((v < 0) ? 0 : (v > 63) ? 63 : v);
  endfunction

  task automatic add_line(input int xs, input int ys, input int xe, input int ye,
                          input logic [COLOR_W-1:0] color);
    line_req_t r;
    r.xs = fit_coord(xs);
    r.ys = fit_coord(ys);
    r.xe = fit_coord(xe);
    r.ye = fit_coord(ye);
    r.color = color;
    line_requests.push_back(r);
    lines_queued++;
  endtask

  // Driver: present the next request once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_line_pixels(next_req);
        lines_accepted++;
      end
      if (!start || !busy) begin
        // no idling for a stretch in the middle of the run
        if (line_requests.size() > 0 &&
            !((lines_issued < 150 || lines_issued >= 250) && $urandom_range(99) < 10)) begin
          next_req = line_requests.pop_front();
          lines_issued++;
          start <= 1'b1;
          x_start <= next_req.xs;
          y_start <= next_req.ys;
          x_end <= next_req.xe;
          y_end <= next_req.ye;
          line_color <= next_req.color;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed pixel must match the oldest expectation
  always @(posedge clk) begin
    if (!rst && pixel_valid) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel addr=%0d color=%h last=%b",
                                  pixel_address, pixel_color, last_pixel));
      end else begin
        got_pixel = expected_pixels.pop_front();
        if (pixel_address !== got_pixel.address)
          report_mismatch($sformatf("pixel_address got %0d exp %0d",
                                    pixel_address, got_pixel.address));
        if (pixel_color !== got_pixel.color)
          report_mismatch($sformatf("pixel_color got %h exp %h",
                                    pixel_color, got_pixel.color));
        if (last_pixel !== got_pixel.last)
          report_mismatch($sformatf("last_pixel got %b exp %b at addr %0d",
                                    last_pixel, got_pixel.last, got_pixel.address));
      end
    end
  end

  initial begin
    int i, kind, xs, ys, len;
    // directed lines
    add_line(0, 0, 0, 0, 32'h0000_0000);
    add_line(63, 63, 63, 63, 32'hFFFF_FFFF);
    add_line(0, 0, 63, 0, 32'h5555_5555);
    add_line(63, 63, 0, 63, 32'hAAAA_AAAA);
    add_line(5, 0, 5, 63, 32'h1234_5678);
    add_line(40, 63, 40, 0, 32'h8765_4321);
    add_line(0, 0, 63, 63, 32'hFFFF_0000);
    add_line(0, 63, 63, 0, 32'h0000_FFFF);
    add_line(63, 0, 0, 63, 32'h0F0F_0F0F);
    add_line(3, 10, 50, 27, 32'hF0F0_F0F0);
    add_line(60, 5, 2, 40, 32'hDEAD_BEEF);
    add_line(2, 45, 61, 7, 32'hCAFE_F00D);
    add_line(10, 2, 25, 60, 32'h0000_0001);
    add_line(25, 60, 10, 2, 32'h8000_0000);
    add_line(30, 55, 33, 4, 32'h7FFF_FFFF);
    add_line(33, 4, 30, 55, 32'h0101_0101);
    add_line(0, 1, 63, 2, 32'hFEFE_FEFE);
    add_line(20, 20, 21, 21, 32'h3C3C_3C3C);
    add_line(20, 21, 21, 20, 32'hC3C3_C3C3);
    add_line(0, 0, 1, 63, 32'h2468_ACE0);
    add_line(17, 33, 17, 33, 32'h1357_9BDF);

    for (i = 0; i < RANDOM_LINES; i++) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        add_line($urandom_range(63), $urandom_range(63), $urandom_range(63),
                 $urandom_range(63), $urandom);
      end else if (kind < 75) begin
        xs = $urandom_range(63);
        ys = $urandom_range(63);
        add_line(xs, ys, xs + int'($urandom_range(8)) - 4, ys + int'($urandom_range(8)) - 4,
                 $urandom);
      end else if (kind < 92) begin
        xs = $urandom_range(63);
        ys = $urandom_range(63);
        len = int'($urandom_range(63)) - 31;
        case ($urandom_range(3))
          0: add_line(xs, ys, xs + len, ys, $urandom);
          1: add_line(xs, ys, xs, ys + len, $urandom);
          2: add_line(xs, ys, xs + len, ys + len, $urandom);
          default: add_line(xs, ys, xs + len, ys - len, $urandom);
        endcase
      end else begin
        xs = $urandom_range(63);
        ys = $urandom_range(63);
        add_line(xs, ys, xs, ys, $urandom);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (lines_accepted < lines_queued) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    // catch stray writes after the last line
    repeat (FRACTION_BITS + 80) @(posedge clk);
    if (error_count == 0) begin
      $display("dda_line_rasterizer_tb: PASS");
    end else begin
      $display("dda_line_rasterizer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("dda_line_rasterizer_tb: FAIL");
    $finish;
  end

endmodule
